@@ hw/rtl/suv_pkg.sv @@
// Package for the strict URL validator: item and verdict types, parse phases,
// reject codes and the scheme prefix table. No dependencies.
`timescale 1ns / 1ps
package suv_pkg;

	localparam int DEF_MAX_URL_BYTES  = 2048;
	localparam int DEF_MAX_HOST_BYTES = 255;
	localparam int FIFO_DEPTH         = 4;
	localparam int HOST_CNT_W         = 9;
	localparam int LABEL_MAX          = 63;
	localparam int PORT_MAX           = 65535;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
	localparam logic [2:0] ERR_MALFORMED = 3'd2;
	localparam logic [2:0] ERR_SCHEME    = 3'd3;
	localparam logic [2:0] ERR_NO_HOST   = 3'd4;
	localparam logic [2:0] ERR_HOST      = 3'd5;
	localparam logic [2:0] ERR_PORT      = 3'd6;
	localparam logic [2:0] ERR_PATH      = 3'd7;

	localparam logic [1:0] SK_NONE  = 2'd0;
	localparam logic [1:0] SK_HTTP  = 2'd1;
	localparam logic [1:0] SK_HTTPS = 2'd2;
	localparam logic [1:0] SK_ABOUT = 2'd3;

	localparam logic [1:0] PK_EMPTY = 2'd0;
	localparam logic [1:0] PK_SLASH = 2'd1;
	localparam logic [1:0] PK_INPUT = 2'd2;

	typedef enum logic [2:0] {
		PH_SCHEME,
		PH_ABOUT,
		PH_HOST,
		PH_PORT,
		PH_PATH,
		PH_QUERY,
		PH_DEAD
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  reject_code;
		logic [1:0]  scheme_kind;
		logic        secure;
		logic [15:0] port_number;
		logic [11:0] host_offset;
		logic [7:0]  host_length;
		logic [1:0]  path_kind;
		logic [11:0] path_offset;
		logic [11:0] path_length;
	} res_t;

	// byte after classification, as held in the queue
	typedef struct packed {
		logic [7:0] b;
		logic [7:0] lc;
		logic [4:0] hexv;
		logic       has;
		logic       last;
		logic       is_ctrl;
		logic       is_alnum;
		logic       is_digit;
	} cls_t;

	function automatic logic [3:0] scheme_len(input logic [1:0] k);
		unique case (k)
			2'd0:    scheme_len = 4'd7;
			2'd1:    scheme_len = 4'd8;
			default: scheme_len = 4'd11;
		endcase
	endfunction

	function automatic logic [7:0] scheme_char(input logic [1:0] k, input logic [3:0] i);
		logic [7:0] c;
		c = 8'h00;
		unique case (k)
			2'd0: begin
				unique case (i)
					4'd0, 4'd1+4'd0: c = (i == 4'd0) ? "h" : "t";
					4'd2: c = "t";
					4'd3: c = "p";
					4'd4: c = ":";
					4'd5, 4'd6: c = "/";
					default: c = 8'h00;
				endcase
			end
			2'd1: begin
				unique case (i)
					4'd0: c = "h";
					4'd1, 4'd2: c = "t";
					4'd3: c = "p";
					4'd4: c = "s";
					4'd5: c = ":";
					4'd6, 4'd7: c = "/";
					default: c = 8'h00;
				endcase
			end
			default: begin
				unique case (i)
					4'd0: c = "a";
					4'd1: c = "b";
					4'd2: c = "o";
					4'd3: c = "u";
					4'd4: c = "t";
					4'd5: c = ":";
					4'd6: c = "b";
					4'd7: c = "l";
					4'd8: c = "a";
					4'd9: c = "n";
					4'd10: c = "k";
					default: c = 8'h00;
				endcase
			end
		endcase
		scheme_char = c;
	endfunction

	function automatic logic [2:0] latch_err(input logic [2:0] e, input logic [2:0] c);
		latch_err = (e == ERR_NONE) ? c : e;
	endfunction

endpackage

@@ hw/rtl/suv_chan_if.sv @@
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from suv_pkg.
`timescale 1ns / 1ps
interface suv_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/suv_front.sv @@
// Front end: takes input transactions and classifies each byte for the parser.
// Depends on suv_pkg and suv_chan_if.
`timescale 1ns / 1ps
module suv_front
	import suv_pkg::*;
(
	suv_chan_if.sink   in_ch,
	input  logic       full,
	output logic       push,
	output cls_t       item
);
	logic [7:0] b;

	assign b            = in_ch.data.data_byte;
	assign in_ch.ready  = !full;
	assign push         = in_ch.valid && !full;

	always_comb begin
		item          = '0;
		item.b        = b;
		item.has      = in_ch.data.has_byte;
		item.last     = in_ch.data.is_last;
		item.lc       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		item.is_ctrl  = (b < 8'h20) || (b == 8'h7f);
		item.is_digit = (b >= "0" && b <= "9");
		item.is_alnum = item.is_digit || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		if (item.is_digit)
			item.hexv = {1'b0, b[3:0]};
		else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
			item.hexv = 5'(b[3:0] + 4'd9);
		else
			item.hexv = 5'd16;
	end
endmodule

@@ hw/rtl/suv_queue.sv @@
// Short queue of classified bytes between front end and parser.
// Depends on suv_pkg.
`timescale 1ns / 1ps
module suv_queue
	import suv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_item,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cls_t head
);
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	cls_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end
endmodule

@@ hw/rtl/suv_back.sv @@
// Back end: running URL parser over classified bytes and the verdict register.
// Depends on suv_pkg and suv_chan_if.
`timescale 1ns / 1ps
module suv_back
	import suv_pkg::*;
#(
	parameter int MAX_URL_BYTES  = DEF_MAX_URL_BYTES,
	parameter int MAX_HOST_BYTES = DEF_MAX_HOST_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         not_empty,
	input  cls_t         it,
	output logic         pop,
	suv_chan_if.source   out_ch
);
	localparam int POS_W = $clog2(MAX_URL_BYTES + 2);
	localparam int HC_W  = HOST_CNT_W;

	phase_t          phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n, pstart_q, pstart_n;
	logic [2:0]      err_q, err_n;
	logic [1:0]      sch_q, sch_n;
	logic [3:0]      pidx_q, pidx_n;
	logic [2:0]      cand_q, cand_n;
	logic            at_q, at_n;
	logic [HC_W-1:0] hc_q, hc_n;
	logic [6:0]      lbl_q, lbl_n;
	logic [1:0]      esc_q, esc_n;
	logic [3:0]      ehi_q, ehi_n;
	logic [16:0]     pv_q, pv_n;
	logic [2:0]      pdig_q, pdig_n;
	logic            ctrl_q, ctrl_n;
	logic            pseen_q, pseen_n;
	logic [1:0]      pk_q, pk_n;
	logic            term, about;
	logic [2:0]      code;
	res_t            res_n, res_q;
	logic            out_valid_q;

	function automatic logic [2:0] host_end_err(input logic [2:0] e, input logic [HC_W-1:0] hc,
			input logic [1:0] esc, input logic [6:0] lbl);
		if (hc == '0)
			host_end_err = latch_err(e, ERR_NO_HOST);
		else if (esc != 2'd0 || lbl == 7'd0 || hc > HC_W'(MAX_HOST_BYTES))
			host_end_err = latch_err(e, ERR_HOST);
		else
			host_end_err = e;
	endfunction

	// clear the parse state, as after reset and after each verdict
	task automatic phase_n_clear();
		phase_q <= PH_SCHEME; pos_q <= '0; pstart_q <= '0; err_q <= ERR_NONE;
		sch_q <= SK_NONE; pidx_q <= '0; cand_q <= 3'b111; at_q <= 1'b0;
		hc_q <= '0; lbl_q <= '0; esc_q <= '0; ehi_q <= '0;
		pv_q <= '0; pdig_q <= '0; ctrl_q <= 1'b0; pseen_q <= 1'b0;
		pk_q <= PK_EMPTY;
	endtask

	assign pop           = not_empty && (!it.last || !out_valid_q || out_ch.ready);
	assign out_ch.valid  = out_valid_q;
	assign out_ch.data   = res_q;
	assign term          = (it.b == "/") || (it.b == "?") || (it.b == "#");

	always_comb begin
		phase_n = phase_q; pos_n = pos_q; pstart_n = pstart_q; err_n = err_q;
		sch_n = sch_q; pidx_n = pidx_q; cand_n = cand_q; at_n = at_q; hc_n = hc_q;
		lbl_n = lbl_q; esc_n = esc_q; ehi_n = ehi_q; pv_n = pv_q; pdig_n = pdig_q;
		ctrl_n = ctrl_q; pseen_n = pseen_q; pk_n = pk_q;
		about = 1'b0;
		code  = ERR_NONE;
		res_n = '0;

		if (it.has) begin
			ctrl_n = ctrl_q | it.is_ctrl;
			unique case (phase_q)
				PH_SCHEME: begin
					for (int k = 0; k < 3; k++) begin
						if (cand_q[k] && (pidx_q >= scheme_len(2'(k)) ||
								scheme_char(2'(k), pidx_q) != it.lc))
							cand_n[k] = 1'b0;
					end
					if (pidx_q < 4'd15)
						pidx_n = pidx_q + 4'd1;
					priority if (cand_n == 3'b000) begin
						err_n   = latch_err(err_n, ERR_SCHEME);
						phase_n = PH_DEAD;
					end else if (cand_n[0] && pidx_n == 4'd7) begin
						sch_n   = SK_HTTP;
						phase_n = PH_HOST;
					end else if (cand_n[1] && pidx_n == 4'd8) begin
						sch_n   = SK_HTTPS;
						phase_n = PH_HOST;
					end else if (cand_n[2] && pidx_n == 4'd11) begin
						phase_n = PH_ABOUT;
					end
				end
				PH_ABOUT: begin
					err_n   = latch_err(err_n, ERR_SCHEME);
					phase_n = PH_DEAD;
				end
				PH_HOST: begin
					if (it.b == ":" || term) begin
						err_n = host_end_err(err_n, hc_q, esc_q, lbl_q);
						esc_n = 2'd0;
						if (it.b == ":") begin
							pseen_n = 1'b1;
							phase_n = PH_PORT;
						end else if (it.b == "/") begin
							pstart_n = pos_q;
							pk_n     = PK_INPUT;
							phase_n  = PH_PATH;
						end else begin
							pk_n    = PK_SLASH;
							phase_n = PH_QUERY;
						end
					end else begin
						if (hc_q <= HC_W'(MAX_HOST_BYTES))
							hc_n = hc_q + 1'b1;
						if (it.b == "@")
							at_n = 1'b1;
						priority if (esc_q != 2'd0) begin
							if (it.hexv > 5'd15)
								err_n = latch_err(err_n, ERR_HOST);
							esc_n = esc_q - 2'd1;
						end else if (it.b == " " || it.b == "\\" || it.b == "@" ||
								it.b == "[" || it.b == "]" || it.b < 8'h21) begin
							err_n = latch_err(err_n, ERR_HOST);
						end else if (it.b == ".") begin
							if (lbl_q == 7'd0)
								err_n = latch_err(err_n, ERR_HOST);
							lbl_n = 7'd0;
						end else if (it.b == "%") begin
							esc_n = 2'd2;
						end else if ((it.b == "-" && lbl_q == 7'd0) ||
								(it.b != "-" && !it.is_alnum)) begin
							err_n = latch_err(err_n, ERR_HOST);
						end else begin
							if (lbl_q < 7'd64)
								lbl_n = lbl_q + 7'd1;
							if (lbl_n > 7'(LABEL_MAX))
								err_n = latch_err(err_n, ERR_HOST);
						end
					end
				end
				PH_PORT: begin
					if (term) begin
						if (pdig_q == 3'd0)
							err_n = latch_err(err_n, ERR_PORT);
						if (it.b == "/") begin
							pstart_n = pos_q;
							pk_n     = PK_INPUT;
							phase_n  = PH_PATH;
						end else begin
							pk_n    = PK_SLASH;
							phase_n = PH_QUERY;
						end
					end else begin
						if (it.b == "@")
							at_n = 1'b1;
						if (it.is_digit && pdig_q < 3'd5) begin
							pv_n = 17'((21'(pv_q) << 3) + (21'(pv_q) << 1) +
								21'(it.hexv[3:0]));
							pdig_n = pdig_q + 3'd1;
							if (pv_n > 17'(PORT_MAX))
								err_n = latch_err(err_n, ERR_PORT);
						end else begin
							err_n = latch_err(err_n, ERR_PORT);
						end
					end
				end
				PH_PATH: begin
					priority if (esc_q == 2'd2) begin
						if (it.hexv > 5'd15) begin
							err_n = latch_err(err_n, ERR_PATH);
							esc_n = 2'd0;
						end else begin
							ehi_n = it.hexv[3:0];
							esc_n = 2'd1;
						end
					end else if (esc_q == 2'd1) begin
						esc_n = 2'd0;
						if (it.hexv > 5'd15 || {ehi_q, it.hexv[3:0]} < 8'h20 ||
								{ehi_q, it.hexv[3:0]} == 8'h7f)
							err_n = latch_err(err_n, ERR_PATH);
					end else if (it.b == "%") begin
						esc_n = 2'd2;
					end
				end
				default: ;
			endcase
			if (pos_q <= POS_W'(MAX_URL_BYTES))
				pos_n = pos_q + 1'b1;
		end

		if (it.last) begin
			unique case (phase_n)
				PH_SCHEME: err_n = latch_err(err_n, ERR_SCHEME);
				PH_ABOUT:  about = 1'b1;
				PH_HOST:   err_n = host_end_err(err_n, hc_n, esc_n, lbl_n);
				PH_PORT:   if (pdig_n == 3'd0) err_n = latch_err(err_n, ERR_PORT);
				PH_PATH:   if (esc_n != 2'd0) err_n = latch_err(err_n, ERR_PATH);
				default: ;
			endcase
			priority if (pos_n > POS_W'(MAX_URL_BYTES)) code = ERR_TOO_LONG;
			else if (pos_n == '0 || ctrl_n)             code = ERR_MALFORMED;
			else if (err_n == ERR_SCHEME)               code = ERR_SCHEME;
			else if (about)                             code = ERR_NONE;
			else if (at_n)                              code = ERR_HOST;
			else                                        code = err_n;

			res_n.reject_code = code;
			if (code == ERR_NONE && about) begin
				res_n.accepted    = 1'b1;
				res_n.scheme_kind = SK_ABOUT;
			end else begin
				res_n.scheme_kind = sch_n;
				res_n.secure      = (sch_n == SK_HTTPS);
				if (code == ERR_NONE) begin
					res_n.accepted    = 1'b1;
					res_n.port_number = pseen_n ? pv_n[15:0] : 16'd0;
					res_n.host_offset = (sch_n == SK_HTTPS) ? 12'd8 : 12'd7;
					res_n.host_length = hc_n[7:0];
					res_n.path_kind   = pk_n;
					if (pk_n == PK_INPUT) begin
						res_n.path_offset = 12'(pstart_n);
						res_n.path_length = 12'(pos_n - pstart_n);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && it.last)
			res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && it.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_n_clear();
		end else if (pop) begin
			if (it.last) begin
				phase_n_clear();
			end else begin
				phase_q <= phase_n; pos_q <= pos_n; pstart_q <= pstart_n; err_q <= err_n;
				sch_q <= sch_n; pidx_q <= pidx_n; cand_q <= cand_n; at_q <= at_n;
				hc_q <= hc_n; lbl_q <= lbl_n; esc_q <= esc_n; ehi_q <= ehi_n;
				pv_q <= pv_n; pdig_q <= pdig_n; ctrl_q <= ctrl_n; pseen_q <= pseen_n;
				pk_q <= pk_n;
			end
		end
	end
endmodule

@@ hw/rtl/strict_url_validator.sv @@
// Strict URL validator top level: front end, byte queue and parser back end.
// Depends on suv_pkg, suv_chan_if, suv_front, suv_queue and suv_back.
//
// Usage: in_ch carries one URL byte per transaction (data_byte, has_byte,
// is_last). A transaction with is_last ends the URL; out_ch then carries one
// verdict (accept flag, reject code, scheme, port, host and path positions).
// Transactions with has_byte low and is_last low change nothing.
// Throughput: one byte per cycle while in_ch.ready is high; the parser consumes
// one queue entry per cycle with its running state, and the four-entry queue
// absorbs stalls. The verdict is registered when the parser pops the closing
// byte. While a verdict waits on out_ch, bytes of the next URL keep flowing;
// only the next closing byte waits, and in_ch.ready drops once the queue fills.
// Reset (arst_n low) empties the queue, drops out_ch.valid and clears the
// parse state; no clearing pass is needed.
`timescale 1ns / 1ps
module strict_url_validator
	import suv_pkg::*;
#(
	parameter int MAX_URL_BYTES  = DEF_MAX_URL_BYTES,
	parameter int MAX_HOST_BYTES = DEF_MAX_HOST_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	suv_chan_if.sink   in_ch,
	suv_chan_if.source out_ch
);
	logic full, push, pop, not_empty;
	cls_t push_item, head;

	suv_front u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.item  (push_item)
	);

	suv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	suv_back #(
		.MAX_URL_BYTES  (MAX_URL_BYTES),
		.MAX_HOST_BYTES (MAX_HOST_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.it        (head),
		.pop       (pop),
		.out_ch    (out_ch)
	);
endmodule

@@ hw/rtl/suv_checker.sv @@
// Port-level checks on the strict URL validator, bound to the top level.
// Depends on suv_pkg.
`timescale 1ns / 1ps
module suv_checker
	import suv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input res_t out_data
);
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict dropped while stalled");

	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.accepted == (out_data.reject_code == ERR_NONE)))
		else $error("accept flag disagrees with reject code");

	a_reject_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |-> (out_data.port_number == 16'd0 &&
			out_data.host_length == 8'd0 && out_data.path_kind == PK_EMPTY))
		else $error("rejected verdict carries positions");

	a_secure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted && out_data.scheme_kind != SK_ABOUT |->
			(out_data.secure == (out_data.scheme_kind == SK_HTTPS) &&
			out_data.host_offset == (out_data.secure ? 12'd8 : 12'd7)))
		else $error("host offset does not match scheme");
endmodule

bind strict_url_validator suv_checker u_suv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
